// ===== rtl/adam_pkg.sv =====
// ----------------------------------------------------------------------------
// Adam update package
// Shared sizes, fixed-point limits, register codes and the item records
// passed between the pipeline sections.
// ----------------------------------------------------------------------------
package adam_pkg;

  localparam int ELEMENTS    = 4096;
  localparam int MOM_AW      = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int IDX_W       = 12;
  localparam int CFG_W       = 32;
  localparam int CORR_STAGES = 48;   // quotient bits of the second-moment correction
  localparam int MHAT_STEPS  = 31;   // quotient bits of the first-moment correction
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 34;

  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
  localparam logic [47:0] V_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] MHAT_MAX  = 31'h7FFF_FFFF;
  localparam logic [33:0] DELTA_MAX = 34'h2_0000_0000;

  localparam logic [23:0] LR_RST    = 24'd16777;
  localparam logic [15:0] BETA1_RST = 16'd58982;
  localparam logic [15:0] BETA2_RST = 16'd65470;
  localparam logic [31:0] EPS_RST   = 32'd43;

  typedef enum logic [1:0] {
    CFG_LR    = 2'd0,
    CFG_BETA1 = 2'd1,
    CFG_BETA2 = 2'd2,
    CFG_EPS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0] lr;
    logic [15:0] beta1;
    logic [15:0] beta2;
    logic [31:0] eps;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] w;
    logic signed [31:0] m;
    logic [47:0]        v;
    logic [31:0]        c1;
    logic [31:0]        c2;
  } mom_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] w;
    logic               m_neg;
    logic [30:0]        mhat;
    logic [47:0]        vhat;
  } cor_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] w;
    logic               m_neg;
    logic [30:0]        mhat;
    logic [31:0]        root;
  } sqrt_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] w;
    logic               m_neg;
    logic [33:0]        delta;
  } scl_item_t;

endpackage

// ===== rtl/adam_optimizer_update_top.sv =====
// ----------------------------------------------------------------------------
// Adam optimizer update, top level
// One weight element per transaction: moments, bias correction, root,
// scaling and the saturated weight update.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: a transaction carries starts_step, element_index,
//   weight_in and gradient. Set starts_step on the first element of each
//   optimizer step. Result channel out_*: weight_out and index_out, one
//   result per transaction, in order.
//   Throughput is one transaction per cycle while in_stall is low, also
//   when the same element follows itself; the moment store forwards the
//   write still in flight. The front end feeds the divider and square-root
//   stages (48 + 32 + 34 bit stages). After reset the moment store is swept
//   to zero, one entry per cycle, and in_stall stays high meanwhile.
//   Configuration writes are taken at any time through cfg_wr_en/cfg_index/
//   cfg_data and must only be issued while no transaction is in flight.
//   When out_stall is high with a result waiting, the whole pipeline holds
//   and in_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module adam_optimizer_update_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_index,
  input  logic [adam_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_starts_step,
  input  logic [adam_pkg::IDX_W-1:0] in_element_index,
  input  logic signed [31:0]         in_weight_in,
  input  logic signed [31:0]         in_gradient,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_weight_out,
  output logic [adam_pkg::IDX_W-1:0] out_index_out
);
  import adam_pkg::*;

  cfg_t        cfg_r;
  logic        en, in_fire, clr_busy;
  logic        mom_vld, cor_vld, sq_vld, scl_vld;
  mom_item_t   mom_item;
  cor_item_t   cor_item;
  sqrt_item_t  sq_item;
  scl_item_t   scl_item;
  logic signed [35:0] res;
  logic signed [31:0] res_sat;

  logic               out_valid_r;
  logic signed [31:0] out_weight_r;
  logic [IDX_W-1:0]   out_index_r;

  // advance unless a finished result is held by the receiver
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en || clr_busy;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lr    <= LR_RST;
      cfg_r.beta1 <= BETA1_RST;
      cfg_r.beta2 <= BETA2_RST;
      cfg_r.eps   <= EPS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LR:    cfg_r.lr    <= cfg_data[23:0];
        CFG_BETA1: cfg_r.beta1 <= cfg_data[15:0];
        CFG_BETA2: cfg_r.beta2 <= cfg_data[15:0];
        CFG_EPS:   cfg_r.eps   <= cfg_data[31:0];
        default:   ;
      endcase
    end
  end

  adam_moment u_moment (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .in_vld   (in_fire),
    .in_starts(in_starts_step),
    .in_idx   (in_element_index),
    .in_w     (in_weight_in),
    .in_g     (in_gradient),
    .clr_busy (clr_busy),
    .out_vld  (mom_vld),
    .out_item (mom_item)
  );

  adam_correct u_correct (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (mom_vld),
    .in_item (mom_item),
    .out_vld (cor_vld),
    .out_item(cor_item)
  );

  adam_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (cor_vld),
    .in_item (cor_item),
    .out_vld (sq_vld),
    .out_item(sq_item)
  );

  adam_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg_r),
    .in_vld  (sq_vld),
    .in_item (sq_item),
    .out_vld (scl_vld),
    .out_item(scl_item)
  );

  // step against the sign of the first moment, then saturate
  assign res = scl_item.m_neg ? (36'(scl_item.w) + $signed({2'b00, scl_item.delta}))
                              : (36'(scl_item.w) - $signed({2'b00, scl_item.delta}));
  assign res_sat = (res[35:31] == 5'b00000 || res[35:31] == 5'b11111) ? res[31:0] :
                   (res[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= scl_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_weight_r <= res_sat;
      out_index_r  <= scl_item.idx;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_weight_out = out_weight_r;
  assign out_index_out  = out_index_r;

endmodule

// ===== rtl/adam_moment.sv =====
// ----------------------------------------------------------------------------
// Adam moment update
// Four-stage front end: bias powers, gradient products, moment store
// read-modify-write with forwarding, and the correction divisors.
// ----------------------------------------------------------------------------
module adam_moment (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  adam_pkg::cfg_t             cfg,
  input  logic                       in_vld,
  input  logic                       in_starts,
  input  logic [adam_pkg::IDX_W-1:0] in_idx,
  input  logic signed [31:0]         in_w,
  input  logic signed [31:0]         in_g,
  output logic                       clr_busy,
  output logic                       out_vld,
  output adam_pkg::mom_item_t        out_item
);
  import adam_pkg::*;

  // moment store: {first moment, second moment}
  logic [79:0] mem [ELEMENTS];
  logic [79:0] rd_r;
  logic              clr_busy_r;
  logic [MOM_AW-1:0] clr_cnt_r;

  logic [31:0] pow1_r, pow2_r, pow1_nxt, pow2_nxt;
  logic [31:0] step_cnt_r, step_cnt_nxt;
  logic [47:0] p1_prod, p2_prod;

  // stage 1
  logic                v1_r, st1_r;
  logic [IDX_W-1:0]    idx1_r;
  logic signed [31:0]  w1_r, g1_r;
  logic [16:0]         k1;
  logic signed [49:0]  k1g;
  logic signed [63:0]  gg;

  // stage 2
  logic                v2_r;
  logic [IDX_W-1:0]    idx2_r;
  logic signed [31:0]  w2_r;
  logic signed [49:0]  k1g2_r;
  logic [46:0]         gsq2_r;
  logic [31:0]         p1_2_r, p2_2_r;
  logic [16:0]         k2;
  logic [63:0]         k2gsq;
  logic [31:0]         c1_raw, c2_raw;

  // stage 3
  logic                v3_r;
  logic [IDX_W-1:0]    idx3_r;
  logic signed [31:0]  w3_r;
  logic signed [49:0]  k1g3_r;
  logic [63:0]         k2gsq3_r;
  logic [31:0]         c1_3_r, c2_3_r;
  logic                inr3, fwd3;
  logic signed [31:0]  m_old, m_new;
  logic [47:0]         v_old, v_new;
  logic signed [48:0]  bm;
  logic [63:0]         bv;
  logic signed [50:0]  m_acc;
  logic [65:0]         v_acc;
  logic signed [34:0]  m_sh;
  logic [49:0]         v_sh;

  // stage 4
  logic                v4_r;
  logic [IDX_W-1:0]    idx4_r;
  logic signed [31:0]  w4_r, m4_r;
  logic [47:0]         vn4_r;
  logic [31:0]         c1_4_r, c2_4_r;

  // ---- bias powers and step count
  assign p1_prod  = pow1_r * cfg.beta1;
  assign p2_prod  = pow2_r * cfg.beta2;
  assign pow1_nxt = (v1_r && st1_r) ? p1_prod[47:16] : pow1_r;
  assign pow2_nxt = (v1_r && st1_r) ? p2_prod[47:16] : pow2_r;
  assign step_cnt_nxt = (v1_r && st1_r && (step_cnt_r != '1)) ? step_cnt_r + 32'd1
                                                             : step_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow1_r     <= ONE_Q31;
      pow2_r     <= ONE_Q31;
      step_cnt_r <= '0;
    end else if (en) begin
      pow1_r     <= pow1_nxt;
      pow2_r     <= pow2_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  // ---- clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == MOM_AW'(ELEMENTS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end
  assign clr_busy = clr_busy_r;

  // ---- datapath
  assign k1  = 17'h10000 - {1'b0, cfg.beta1};
  assign k1g = $signed({1'b0, k1}) * g1_r;
  assign gg  = g1_r * g1_r;

  assign k2     = 17'h10000 - {1'b0, cfg.beta2};
  assign k2gsq  = k2 * gsq2_r;
  assign c1_raw = ONE_Q31 - p1_2_r;
  assign c2_raw = ONE_Q31 - p2_2_r;

  // out-of-range index reads zero and writes nothing
  assign inr3  = (32'(idx3_r) < ELEMENTS);
  // the item one ahead wrote this entry as this one was read
  assign fwd3  = v4_r && (idx4_r == idx3_r);
  assign m_old = !inr3 ? 32'sd0 : (fwd3 ? m4_r : $signed(rd_r[79:48]));
  assign v_old = !inr3 ? 48'd0 : (fwd3 ? vn4_r : rd_r[47:0]);

  assign bm    = $signed({1'b0, cfg.beta1}) * m_old;
  assign m_acc = 51'(bm) + 51'(k1g3_r) + 51'sd32768;
  assign m_sh  = m_acc[50:16];
  assign m_new = (m_sh[34:31] == 4'b0000 || m_sh[34:31] == 4'b1111) ? m_sh[31:0] :
                 (m_sh[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  assign bv    = cfg.beta2 * v_old;
  assign v_acc = 66'(bv) + 66'(k2gsq3_r) + 66'd32768;
  assign v_sh  = v_acc[65:16];
  assign v_new = (v_sh[49:48] != 2'b00) ? V_MAX : v_sh[47:0];

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (en && v3_r && inr3) begin
      mem[MOM_AW'(idx3_r)] <= {m_new, v_new};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r <= mem[MOM_AW'(idx2_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r    <= in_starts;
      idx1_r   <= in_idx;
      w1_r     <= in_w;
      g1_r     <= in_g;

      idx2_r   <= idx1_r;
      w2_r     <= w1_r;
      k1g2_r   <= k1g;
      gsq2_r   <= gg[62:16];
      p1_2_r   <= pow1_nxt;
      p2_2_r   <= pow2_nxt;

      idx3_r   <= idx2_r;
      w3_r     <= w2_r;
      k1g3_r   <= k1g2_r;
      k2gsq3_r <= k2gsq;
      c1_3_r   <= (c1_raw == 32'd0) ? ONE_Q31 : c1_raw;
      c2_3_r   <= (c2_raw == 32'd0) ? ONE_Q31 : c2_raw;

      idx4_r   <= idx3_r;
      w4_r     <= w3_r;
      m4_r     <= m_new;
      vn4_r    <= v_new;
      c1_4_r   <= c1_3_r;
      c2_4_r   <= c2_3_r;
    end
  end

  assign out_vld     = v4_r;
  assign out_item.idx = idx4_r;
  assign out_item.w   = w4_r;
  assign out_item.m   = m4_r;
  assign out_item.v   = vn4_r;
  assign out_item.c1  = c1_4_r;
  assign out_item.c2  = c2_4_r;

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !v1_r)
    else $error("item entered during moment store clearing");

  a_step_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> step_cnt_r >= $past(step_cnt_r))
    else $error("step count went backwards");

  a_pow_moves_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (pow1_r != $past(pow1_r))) |-> $past(en && v1_r && st1_r))
    else $error("decay power changed without a step start");

endmodule

// ===== rtl/adam_correct.sv =====
// ----------------------------------------------------------------------------
// Adam bias correction
// Two restoring dividers in lock step, one quotient bit per stage:
// |m| * 2^31 / c1 and v * 2^31 / c2, each saturated.
// ----------------------------------------------------------------------------
module adam_correct (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  adam_pkg::mom_item_t in_item,
  output logic                out_vld,
  output adam_pkg::cor_item_t out_item
);
  import adam_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] w;
    logic               m_neg;
    logic [31:0]        c1;
    logic [31:0]        c2;
    logic               ovf_m;
    logic               ovf_v;
    logic [31:0]        mrem;
    logic [30:0]        mq;
    logic [31:0]        vrem;
    logic [16:0]        vlow;
    logic [47:0]        vq;
  } cor_st_t;

  function automatic cor_st_t cor_step(cor_st_t s, logic m_on);
    cor_st_t    o;
    logic [32:0] mr2;
    logic [32:0] vr2;
    o   = s;
    mr2 = {s.mrem, 1'b0};
    vr2 = {s.vrem, s.vlow[16]};
    o.vlow = {s.vlow[15:0], 1'b0};
    if (vr2 >= {1'b0, s.c2}) begin
      o.vrem = 32'(vr2 - {1'b0, s.c2});
      o.vq   = {s.vq[46:0], 1'b1};
    end else begin
      o.vrem = vr2[31:0];
      o.vq   = {s.vq[46:0], 1'b0};
    end
    if (m_on) begin
      if (mr2 >= {1'b0, s.c1}) begin
        o.mrem = 32'(mr2 - {1'b0, s.c1});
        o.mq   = {s.mq[29:0], 1'b1};
      end else begin
        o.mrem = mr2[31:0];
        o.mq   = {s.mq[29:0], 1'b0};
      end
    end
    return o;
  endfunction

  cor_st_t                st_r [CORR_STAGES+1];
  logic [CORR_STAGES:0]   vld_r;
  cor_st_t                entry;
  logic [31:0]            mag;
  cor_st_t                last;

  assign mag = in_item.m[31] ? 32'(-in_item.m) : in_item.m;

  always_comb begin
    entry       = '0;
    entry.idx   = in_item.idx;
    entry.w     = in_item.w;
    entry.m_neg = in_item.m[31];
    entry.c1    = in_item.c1;
    entry.c2    = in_item.c2;
    // quotient would not fit: saturate at the end
    entry.ovf_m = (mag >= in_item.c1);
    entry.ovf_v = ({1'b0, in_item.v[47:17]} >= in_item.c2);
    entry.mrem  = entry.ovf_m ? 32'd0 : mag;
    entry.vrem  = entry.ovf_v ? 32'd0 : {1'b0, in_item.v[47:17]};
    entry.vlow  = in_item.v[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[CORR_STAGES-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= entry;
    end
  end

  for (genvar k = 0; k < CORR_STAGES; k++) begin : g_stg
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= cor_step(st_r[k], (k < MHAT_STEPS));
      end
    end
  end

  assign last           = st_r[CORR_STAGES];
  assign out_vld        = vld_r[CORR_STAGES];
  assign out_item.idx   = last.idx;
  assign out_item.w     = last.w;
  assign out_item.m_neg = last.m_neg;
  assign out_item.mhat  = last.ovf_m ? MHAT_MAX : last.mq;
  assign out_item.vhat  = last.ovf_v ? V_MAX : last.vq;

endmodule

// ===== rtl/adam_sqrt.sv =====
// ----------------------------------------------------------------------------
// Adam square root
// Digit-by-digit integer square root of v_hat * 2^16, one root bit per stage.
// ----------------------------------------------------------------------------
module adam_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  adam_pkg::cor_item_t  in_item,
  output logic                 out_vld,
  output adam_pkg::sqrt_item_t out_item
);
  import adam_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] w;
    logic               m_neg;
    logic [30:0]        mhat;
    logic [63:0]        x;
    logic [33:0]        rem;
    logic [31:0]        root;
  } sq_st_t;

  function automatic sq_st_t sq_step(sq_st_t s);
    sq_st_t      o;
    logic [35:0] r4;
    logic [35:0] trial;
    o     = s;
    r4    = {s.rem, s.x[63:62]};
    trial = {2'b00, s.root, 2'b01};
    o.x   = {s.x[61:0], 2'b00};
    if (r4 >= trial) begin
      o.rem  = 34'(r4 - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r4[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  sq_st_t               st_r [SQRT_STAGES+1];
  logic [SQRT_STAGES:0] vld_r;
  sq_st_t               entry;

  always_comb begin
    entry       = '0;
    entry.idx   = in_item.idx;
    entry.w     = in_item.w;
    entry.m_neg = in_item.m_neg;
    entry.mhat  = in_item.mhat;
    entry.x     = {in_item.vhat, 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STAGES-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= entry;
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stg
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= sq_step(st_r[k]);
      end
    end
  end

  assign out_vld        = vld_r[SQRT_STAGES];
  assign out_item.idx   = st_r[SQRT_STAGES].idx;
  assign out_item.w     = st_r[SQRT_STAGES].w;
  assign out_item.m_neg = st_r[SQRT_STAGES].m_neg;
  assign out_item.mhat  = st_r[SQRT_STAGES].mhat;
  assign out_item.root  = st_r[SQRT_STAGES].root;

endmodule

// ===== rtl/adam_scale.sv =====
// ----------------------------------------------------------------------------
// Adam step scaling
// lr * m_hat product and denominator, then a restoring divider giving the
// weight delta, one quotient bit per stage, capped.
// ----------------------------------------------------------------------------
module adam_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  adam_pkg::cfg_t       cfg,
  input  logic                 in_vld,
  input  adam_pkg::sqrt_item_t in_item,
  output logic                 out_vld,
  output adam_pkg::scl_item_t  out_item
);
  import adam_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] w;
    logic               m_neg;
    logic               ovf;
    logic [40:0]        d;
    logic [40:0]        rem;
    logic [33:0]        low;
    logic [33:0]        q;
  } dv_st_t;

  function automatic dv_st_t dv_step(dv_st_t s);
    dv_st_t      o;
    logic [41:0] r2;
    o     = s;
    r2    = {s.rem, s.low[33]};
    o.low = {s.low[32:0], 1'b0};
    if (r2 >= {1'b0, s.d}) begin
      o.rem = 41'(r2 - {1'b0, s.d});
      o.q   = {s.q[32:0], 1'b1};
    end else begin
      o.rem = r2[40:0];
      o.q   = {s.q[32:0], 1'b0};
    end
    return o;
  endfunction

  // product stage
  logic                vp_r;
  logic [IDX_W-1:0]    idxp_r;
  logic signed [31:0]  wp_r;
  logic                negp_r;
  logic [54:0]         prod, prod_r;
  logic [40:0]         dsum, d_r;

  dv_st_t              st_r [DIV_STAGES+1];
  logic [DIV_STAGES:0] vld_r;
  dv_st_t              entry;
  dv_st_t              last;

  assign prod = cfg.lr * in_item.mhat;
  assign dsum = {1'b0, in_item.root, 8'h00} + 41'(cfg.eps);

  always_ff @(posedge clk) begin
    if (en) begin
      idxp_r <= in_item.idx;
      wp_r   <= in_item.w;
      negp_r <= in_item.m_neg;
      prod_r <= prod;
      // zero denominator counts as one LSB
      d_r    <= (dsum == 41'd0) ? 41'd1 : dsum;
    end
  end

  always_comb begin
    entry       = '0;
    entry.idx   = idxp_r;
    entry.w     = wp_r;
    entry.m_neg = negp_r;
    entry.d     = d_r;
    entry.ovf   = ({12'h000, prod_r[54:26]} >= d_r);
    entry.rem   = entry.ovf ? 41'd0 : {12'h000, prod_r[54:26]};
    entry.low   = {prod_r[25:0], 8'h00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r  <= 1'b0;
      vld_r <= '0;
    end else if (en) begin
      vp_r  <= in_vld;
      vld_r <= {vld_r[DIV_STAGES-1:0], vp_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= entry;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= dv_step(st_r[k]);
      end
    end
  end

  assign last           = st_r[DIV_STAGES];
  assign out_vld        = vld_r[DIV_STAGES];
  assign out_item.idx   = last.idx;
  assign out_item.w     = last.w;
  assign out_item.m_neg = last.m_neg;
  assign out_item.delta = (last.ovf || (last.q > DELTA_MAX)) ? DELTA_MAX : last.q;

endmodule

// ===== bench/tb_adam_optimizer_update_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam update bench
// Streams directed and random weight/gradient transactions through the Adam
// update block under several register settings and idling patterns, predicts
// every updated weight in fixed point and checks each result in order.
// ----------------------------------------------------------------------------
module tb_adam_optimizer_update_top;
  import adam_pkg::*;

  typedef struct {
    logic signed [31:0] w;
    logic [IDX_W-1:0]   idx;
  } upd_t;

  class adam_scoreboard;
    longint first_mom[ELEMENTS];
    longint second_mom[ELEMENTS];
    longint steps, pow1, pow2;
    longint lr_r, b1_r, b2_r, eps_r;
    upd_t   upd_q[$];

    function new();
      foreach (first_mom[i]) begin
        first_mom[i]  = 0;
        second_mom[i] = 0;
      end
      steps = 0;
      pow1 = 64'h8000_0000;
      pow2 = 64'h8000_0000;
      lr_r = LR_RST;
      b1_r = BETA1_RST;
      b2_r = BETA2_RST;
      eps_r = EPS_RST;
    endfunction

    function void set_reg(cfg_reg_t r, logic [31:0] val);
      case (r)
        CFG_LR:    lr_r  = val[23:0];
        CFG_BETA1: b1_r  = val[15:0];
        CFG_BETA2: b2_r  = val[15:0];
        CFG_EPS:   eps_r = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] rem, root, b;
      rem = x;
      root = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem = rem - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    function int pending();
      return upd_q.size();
    endfunction

    function void note_input(logic starts, logic [IDX_W-1:0] idx,
                             logic signed [31:0] wi, logic signed [31:0] gi);
      longint w, g, m_old, v_old, m_new, gsq, v_new, c1, c2, mag, mhat;
      longint a, r, vhat, s, d, delta, res;
      logic [79:0] vacc;
      upd_t e;
      w = wi;
      g = gi;
      if (starts) begin
        if (steps != 64'hFFFF_FFFF) steps++;
        pow1 = (pow1 * b1_r) >> 16;
        pow2 = (pow2 * b2_r) >> 16;
      end
      m_old = first_mom[idx];
      v_old = second_mom[idx];
      m_new = (b1_r * m_old + (65536 - b1_r) * g + 32768) >>> 16;
      if (m_new > 64'sd2147483647) m_new = 64'sd2147483647;
      if (m_new < -64'sd2147483648) m_new = -64'sd2147483648;
      gsq = (g * g) >> 16;
      vacc = 80'(b2_r) * 80'(v_old) + 80'(65536 - b2_r) * 80'(gsq) + 80'd32768;
      vacc = vacc >> 16;
      v_new = (vacc > 80'(V_MAX)) ? longint'(V_MAX) : longint'(vacc[63:0]);
      first_mom[idx]  = m_new;
      second_mom[idx] = v_new;
      c1 = 64'h8000_0000 - pow1;
      c2 = 64'h8000_0000 - pow2;
      // no step taken yet: no correction
      if (c1 == 0) c1 = 64'h8000_0000;
      if (c2 == 0) c2 = 64'h8000_0000;
      mag = (m_new < 0) ? -m_new : m_new;
      mhat = (mag << 31) / c1;
      if (mhat > 64'h7FFF_FFFF) mhat = 64'h7FFF_FFFF;
      a = v_new / c2;
      r = v_new % c2;
      if (a >= (64'd1 << 17)) begin
        vhat = V_MAX;
      end else begin
        vhat = (a << 31) + (r << 31) / c2;
        if (vhat > longint'(V_MAX)) vhat = V_MAX;
      end
      s = int_sqrt(64'(vhat) << 16);
      d = (s << 8) + eps_r;
      if (d == 0) d = 1;
      delta = ((lr_r * mhat) << 8) / d;
      if (delta > longint'(DELTA_MAX)) delta = DELTA_MAX;
      res = (m_new < 0) ? w + delta : w - delta;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      e.w = res[31:0];
      e.idx = idx;
      upd_q.push_back(e);
    endfunction

    function bit check_result(logic signed [31:0] w, logic [IDX_W-1:0] idx,
                              output string msg);
      upd_t e;
      if (upd_q.size() == 0) begin
        msg = $sformatf("unexpected result w=%h idx=%0d", w, idx);
        return 0;
      end
      e = upd_q.pop_front();
      if (e.w !== w || e.idx !== idx) begin
        msg = $sformatf("got w=%h idx=%0d, want w=%h idx=%0d", w, idx, e.w, e.idx);
        return 0;
      end
      return 1;
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_starts_step = 0;
  logic [IDX_W-1:0] in_element_index = 0;
  logic signed [31:0] in_weight_in = 0;
  logic signed [31:0] in_gradient = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_weight_out;
  logic [IDX_W-1:0] out_index_out;

  adam_scoreboard sb;
  int errors = 0;
  int cycles = 0;
  int send_idle = 22;
  int recv_idle = 53;

  adam_optimizer_update_top u_top (.*);

  always #5 clk = ~clk;

  task automatic report(string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("adam_optimizer_update_top: mismatch");
      $finish;
    end
  end

  always @(negedge clk) out_stall = ($urandom_range(0, 99) < recv_idle);

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && !out_stall)
      if (!sb.check_result(out_weight_out, out_index_out, msg)) report(msg);
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_item(logic s, logic [IDX_W-1:0] idx, logic [31:0] w, logic [31:0] g);
    in_valid = 1;
    in_starts_step = s;
    in_element_index = idx;
    in_weight_in = w;
    in_gradient = g;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(s, idx, w, g);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] val);
    cfg_wr_en = 1;
    cfg_index = r;
    cfg_data = val;
    @(posedge clk);
    sb.set_reg(r, val);
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic write_all(logic [31:0] lr, logic [31:0] b1, logic [31:0] b2, logic [31:0] eps);
    write_reg(CFG_LR, lr);
    write_reg(CFG_BETA1, b1);
    write_reg(CFG_BETA2, b2);
    write_reg(CFG_EPS, eps);
  endtask

  function automatic logic [31:0] pick_grad();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom)) >>> $urandom_range(4, 28);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'($signed($urandom)) >>> 20;
      default: return 32'($signed($urandom)) >>> 8;
    endcase
  endfunction

  task automatic random_items(int n);
    int left;
    int burst;
    logic [IDX_W-1:0] idx;
    logic [31:0] w;
    left = n;
    idx = 0;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && left > 0; i++) begin
        case ($urandom_range(0, 9))
          0, 1: idx = IDX_W'($urandom);
          2: ;                       // same element again
          default: idx = IDX_W'($urandom_range(0, 15));
        endcase
        w = ($urandom_range(0, 3) == 0) ? pick_grad() : $urandom;
        // mostly well-formed steps, some stray step flags
        send_item((i == 0) ? 1'b1 : ($urandom_range(0, 19) == 0), idx, w, pick_grad());
        left--;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: before any step, extremes, same element back to back
    send_item(0, 0, 32'h0100_0000, 32'h0001_0000);
    send_item(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(0, 12'hFFF, 32'h8000_0000, 32'h8000_0000);
    send_item(0, 12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(0, 1, 32'h0000_0000, 32'h0000_0000);
    send_item(0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1, 2, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(0, 3, 32'h8000_0000, 32'h0000_0001);
    send_item(0, 12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(0, 12'h555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(1, 0, 32'h0, 32'hFFFF_0000);
    drain();
    // zero denominator: fresh element, zero gradient, eps cleared
    write_all(24'hFF_FFFF, 16'd0, 16'd0, 32'd0);
    send_item(1, 100, 32'h0123_4567, 32'h0);
    send_item(0, 101, 32'h8000_0000, 32'h0);
    send_item(1, 100, 32'h7FFF_FFFF, 32'h0000_0100);
    send_item(0, 100, 32'h8000_0000, 32'h8000_0000);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_all(24'hFF_FFFF, 16'd0, 16'd0, 32'hFFFF_FFFF);
        1: write_all(24'd0, 16'hFFFF, 16'hFFFF, 32'd0);
        2: write_all($urandom, $urandom, $urandom, $urandom_range(0, 3) ? $urandom_range(0, 4095) : $urandom);
        default: write_all(LR_RST, BETA1_RST, BETA2_RST, EPS_RST);
      endcase
      case (p)
        0: begin send_idle = 22; recv_idle = 53; end
        1: begin send_idle = 53; recv_idle = 22; end
        2: begin send_idle = 22; recv_idle = 53; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      random_items(310);
      drain();
    end

    repeat (150) @(posedge clk);
    if (sb.pending() != 0) report($sformatf("%0d results never arrived", sb.pending()));
    if (errors == 0)
      $display("adam_optimizer_update_top: match");
    else
      $display("adam_optimizer_update_top: mismatch");
    $finish;
  end

endmodule
